FILE: rtl/core/bqiw_pkg.sv
package bqiw_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int NPTS            = 4;
  localparam int NCOORDS         = 2 * NPTS + 2;
  localparam int FRAC_OUT        = 28;
  localparam int WEIGHT_WIDTH    = 32;
  // one extra quotient bit flags a weight that cannot fit
  localparam int QBITS           = WEIGHT_WIDTH + 1;

  localparam logic [WEIGHT_WIDTH-1:0] WMAX = 32'h7FFF_FFFF;
  localparam logic [WEIGHT_WIDTH-1:0] WMIN = 32'h8000_0000;

  typedef struct packed {
    logic             singular;
    logic [NPTS-1:0]  neg;
  } div_flags_t;

  // stages of the chunked multiplier: one per 32-bit slice of the wide operand
  function automatic int mul_lat(input int aw);
    return (aw + 31) / 32;
  endfunction

  // differences, three product levels, two adds after the second and third levels
  function automatic int poly_lat(input int w);
    return 1 + mul_lat(w + 1) + mul_lat(2 * w + 2) + 2 + mul_lat(3 * w + 4) + 2;
  endfunction

endpackage

FILE: rtl/core/bqiw_delay.sv
module bqiw_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

FILE: rtl/core/bqiw_mul.sv
module bqiw_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NC = (AW + 31) / 32;
  localparam int XW = NC * 32 + BW + 1;

  logic signed [NC*32-1:0] ae;
  logic signed [32:0]      op  [NC];
  logic signed [XW-1:0]    acc [NC];
  logic signed [XW-1:0]    pp  [NC][NC];

  assign ae = (NC*32)'(a);

  genvar k, s;
  generate
    for (k = 0; k < NC; k++) begin : g_chunk
      // lower slices are unsigned, the top slice carries the sign
      if (k == NC - 1) begin : g_top
        assign op[k] = {ae[32*k+31], ae[32*k +: 32]};
      end else begin : g_low
        assign op[k] = {1'b0, ae[32*k +: 32]};
      end
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (en) acc[0] <= XW'(op[0]) * XW'(b);
        end
      end else begin : g_rest
        always_ff @(posedge clk) begin
          if (en) pp[k][0] <= XW'(op[k]) * XW'(b);
        end
        for (s = 1; s < k; s++) begin : g_hold
          always_ff @(posedge clk) begin
            if (en) pp[k][s] <= pp[k][s-1];
          end
        end
        always_ff @(posedge clk) begin
          if (en) acc[k] <= acc[k-1] + (pp[k][k-1] <<< (32 * k));
        end
      end
    end
  endgenerate

  assign p = acc[NC-1][AW+BW-1:0];

endmodule

FILE: rtl/core/bqiw_poly.sv
module bqiw_poly #(
  parameter int W = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [3:0][W-1:0]       x,
  input  logic [3:0][W-1:0]       y,
  output logic signed [4*W+1:0]   g
);
  import bqiw_pkg::*;

  localparam int DW = W + 1;
  localparam int O1 = 2 * DW;
  localparam int O2 = O1 + W;
  localparam int TW = 3 * W + 4;
  localparam int O3 = TW + W;
  localparam int SW = 4 * W + 5;
  localparam int GW = 4 * W + 2;
  localparam int L1 = mul_lat(DW);
  localparam int L2 = mul_lat(O1);

  logic signed [DW-1:0] d12, d03, d02, d13, d01, d23;
  logic signed [O1-1:0] pa, pb, pc;
  logic signed [O2-1:0] p3, p2, p1, p1d, q12, q13, q23;
  logic [4*W-1:0]       xd1, xd2;
  logic [3*O2-1:0]      qd;
  logic signed [TW-1:0] t1, tt, q12e, q13e, q23e;
  logic signed [O3-1:0] u0, u12, u13, u23;
  logic signed [SW-1:0] s1, s2;

  always_ff @(posedge clk) begin
    if (en) begin
      d12 <= DW'($signed(y[1])) - DW'($signed(y[2]));
      d03 <= DW'($signed(y[0])) - DW'($signed(y[3]));
      d02 <= DW'($signed(y[0])) - DW'($signed(y[2]));
      d13 <= DW'($signed(y[1])) - DW'($signed(y[3]));
      d01 <= DW'($signed(y[0])) - DW'($signed(y[1]));
      d23 <= DW'($signed(y[2])) - DW'($signed(y[3]));
    end
  end

  bqiw_delay #(.WIDTH(4*W), .DEPTH(1+L1)) u_xd1 (.clk, .en, .d(x),   .q(xd1));
  bqiw_delay #(.WIDTH(4*W), .DEPTH(L2+2)) u_xd2 (.clk, .en, .d(xd1), .q(xd2));

  bqiw_mul #(.AW(DW), .BW(DW)) u_ma (.clk, .en, .a(d12), .b(d03), .p(pa));
  bqiw_mul #(.AW(DW), .BW(DW)) u_mb (.clk, .en, .a(d02), .b(d13), .p(pb));
  bqiw_mul #(.AW(DW), .BW(DW)) u_mc (.clk, .en, .a(d01), .b(d23), .p(pc));

  bqiw_mul #(.AW(O1), .BW(W)) u_m3 (.clk, .en, .a(pa), .b($signed(xd1[3*W +: W])), .p(p3));
  bqiw_mul #(.AW(O1), .BW(W)) u_m2 (.clk, .en, .a(pb), .b($signed(xd1[2*W +: W])), .p(p2));
  bqiw_mul #(.AW(O1), .BW(W)) u_m1 (.clk, .en, .a(pc), .b($signed(xd1[W +: W])),   .p(p1));
  bqiw_mul #(.AW(O1), .BW(W)) u_n12 (.clk, .en, .a(pa), .b($signed(xd1[W +: W])),  .p(q12));
  bqiw_mul #(.AW(O1), .BW(W)) u_n13 (.clk, .en, .a(pb), .b($signed(xd1[W +: W])),  .p(q13));
  bqiw_mul #(.AW(O1), .BW(W)) u_n23 (.clk, .en, .a(pc), .b($signed(xd1[2*W +: W])), .p(q23));

  // inner sum for the x0 term
  always_ff @(posedge clk) begin
    if (en) begin
      t1  <= TW'(p3) - TW'(p2);
      p1d <= p1;
      tt  <= t1 + TW'(p1d);
    end
  end

  bqiw_delay #(.WIDTH(3*O2), .DEPTH(2)) u_qd (.clk, .en, .d({q23, q13, q12}), .q(qd));

  assign q12e = TW'($signed(qd[0 +: O2]));
  assign q13e = TW'($signed(qd[O2 +: O2]));
  assign q23e = TW'($signed(qd[2*O2 +: O2]));

  bqiw_mul #(.AW(TW), .BW(W)) u_u0  (.clk, .en, .a(tt),   .b($signed(xd2[0 +: W])),   .p(u0));
  bqiw_mul #(.AW(TW), .BW(W)) u_u12 (.clk, .en, .a(q12e), .b($signed(xd2[2*W +: W])), .p(u12));
  bqiw_mul #(.AW(TW), .BW(W)) u_u13 (.clk, .en, .a(q13e), .b($signed(xd2[3*W +: W])), .p(u13));
  bqiw_mul #(.AW(TW), .BW(W)) u_u23 (.clk, .en, .a(q23e), .b($signed(xd2[3*W +: W])), .p(u23));

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= SW'(u0) + SW'(u12);
      s2 <= SW'(u23) - SW'(u13);
      g  <= GW'(s1 + s2);
    end
  end

endmodule

FILE: rtl/core/bqiw_div_cell.sv
module bqiw_div_cell #(
  parameter int RW  = 163,
  parameter int DNW = 131,
  parameter int QB  = 33,
  parameter int BI  = 0
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [DNW-1:0]         den2_in,
  input  bqiw_pkg::div_flags_t   flags_in,
  input  logic [3:0][RW-1:0]     rem_in,
  input  logic [3:0][QB-1:0]     q_in,
  output logic [DNW-1:0]         den2_out,
  output bqiw_pkg::div_flags_t   flags_out,
  output logic [3:0][RW-1:0]     rem_out,
  output logic [3:0][QB-1:0]     q_out
);
  import bqiw_pkg::*;

  logic [RW-1:0] dsh;
  logic [3:0]    ge;

  assign dsh = RW'(den2_in) << BI;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      ge[l] = rem_in[l] >= dsh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den2_out  <= den2_in;
      flags_out <= flags_in;
      for (int l = 0; l < 4; l++) begin
        rem_out[l] <= ge[l] ? rem_in[l] - dsh : rem_in[l];
        q_out[l]   <= {q_in[l][QB-2:0], ge[l]};
      end
    end
  end

endmodule

FILE: rtl/core/bilinear_quad_interp_weights.sv
// pipeline from accept to m_tvalid: product tree of the five polynomials, two prep stages,
//   one divider cell per quotient bit
// throughput: one item per cycle while the skid slot is empty; all stages advance together
//   behind a two-entry output register and skid slot
// reset: synchronous, clears the valid chain and output flags only
module bilinear_quad_interp_weights #(
  parameter int COORD_WIDTH = bqiw_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // x0, y0, x1, y1, x2, y2, x3, y3, xq, yq from the lowest bit up, zero padded
  input  logic [((bqiw_pkg::NCOORDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // w0, w1, w2, w3 from the lowest bit up
  output logic [bqiw_pkg::NPTS*bqiw_pkg::WEIGHT_WIDTH-1:0]   m_tdata,
  // singular
  output logic m_tuser
);
  import bqiw_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int GW    = 4 * W + 2;
  localparam int DNW   = GW + 1;
  localparam int RW    = GW + 33;
  localparam int LP    = poly_lat(W);
  localparam int NCELL = QBITS;
  localparam int LT    = LP + 2 + NCELL + 1;
  localparam int OW    = NPTS * WEIGHT_WIDTH;

  logic                 en;
  logic [W-1:0]         crd [NCOORDS];
  logic [3:0][W-1:0]    px  [NPTS+1];
  logic [3:0][W-1:0]    py  [NPTS+1];
  logic signed [GW-1:0] gv  [NPTS+1];

  logic [GW-1:0]        aden_r;
  logic [3:0][GW-1:0]   anum_r;
  div_flags_t           flags_r;

  logic [DNW-1:0]       den2_c  [NCELL+1];
  div_flags_t           flags_c [NCELL+1];
  logic [3:0][RW-1:0]   rem_c   [NCELL+1];
  logic [3:0][QBITS-1:0] q_c    [NCELL+1];

  logic [3:0][WEIGHT_WIDTH-1:0] wsat;
  logic [OW-1:0]        p_data, out_data, skid_data;
  logic                 p_user, out_user, skid_user;
  logic [LT-1:0]        vld;
  logic                 p_valid, out_valid, skid_valid, take, inc;

  assign en       = !skid_valid;
  assign s_tready = en;

  genvar i, m, p;
  generate
    for (i = 0; i < NCOORDS; i++) begin : g_crd
      assign crd[i] = s_tdata[W*i +: W];
    end
    // set 0 is the denominator, set k+1 has point k swapped for the query point
    for (m = 0; m <= NPTS; m++) begin : g_poly
      for (p = 0; p < NPTS; p++) begin : g_pt
        assign px[m][p] = (m == p + 1) ? crd[2*NPTS]     : crd[2*p];
        assign py[m][p] = (m == p + 1) ? crd[2*NPTS + 1] : crd[2*p + 1];
      end
      bqiw_poly #(.W(W)) u_poly (.clk, .en, .x(px[m]), .y(py[m]), .g(gv[m]));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      aden_r           <= gv[0][GW-1] ? GW'(-gv[0]) : GW'(gv[0]);
      flags_r.singular <= gv[0] == '0;
      for (int l = 0; l < NPTS; l++) begin
        anum_r[l]      <= gv[l+1][GW-1] ? GW'(-gv[l+1]) : GW'(gv[l+1]);
        flags_r.neg[l] <= gv[l+1][GW-1] ^ gv[0][GW-1];
      end
    end
  end

  // rounded quotient as floor((2^29 |n| + |d|) / 2|d|)
  always_ff @(posedge clk) begin
    if (en) begin
      den2_c[0]  <= {aden_r, 1'b0};
      flags_c[0] <= flags_r;
      for (int l = 0; l < NPTS; l++) begin
        rem_c[0][l] <= (RW'(anum_r[l]) << (FRAC_OUT + 1)) + RW'(aden_r);
        q_c[0][l]   <= '0;
      end
    end
  end

  generate
    for (i = 0; i < NCELL; i++) begin : g_cell
      bqiw_div_cell #(.RW(RW), .DNW(DNW), .QB(QBITS), .BI(NCELL - 1 - i)) u_cell (
        .clk, .en,
        .den2_in(den2_c[i]), .flags_in(flags_c[i]), .rem_in(rem_c[i]), .q_in(q_c[i]),
        .den2_out(den2_c[i+1]), .flags_out(flags_c[i+1]),
        .rem_out(rem_c[i+1]), .q_out(q_c[i+1])
      );
    end
  endgenerate

  always_comb begin
    for (int l = 0; l < NPTS; l++) begin
      if (flags_c[NCELL].singular) begin
        wsat[l] = '0;
      end else if (flags_c[NCELL].neg[l]) begin
        if (q_c[NCELL][l][QBITS-1] || q_c[NCELL][l][WEIGHT_WIDTH-1:0] > WMIN) begin
          wsat[l] = WMIN;
        end else begin
          wsat[l] = -q_c[NCELL][l][WEIGHT_WIDTH-1:0];
        end
      end else if (q_c[NCELL][l][QBITS-1] || q_c[NCELL][l][WEIGHT_WIDTH-1]) begin
        wsat[l] = WMAX;
      end else begin
        wsat[l] = q_c[NCELL][l][WEIGHT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_data <= wsat;
      p_user <= flags_c[NCELL].singular;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LT-2:0], s_tvalid};
    end
  end

  assign p_valid = vld[LT-1];
  assign take    = out_valid && m_tready;
  assign inc     = en && p_valid;

  // the skid slot catches an item while the output register is held
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= inc;
      end
    end else if (inc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_data <= skid_data;
        out_user <= skid_user;
      end else if (inc) begin
        out_data <= p_data;
        out_user <= p_user;
      end
    end else if (inc) begin
      skid_data <= p_data;
      skid_user <= p_user;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

endmodule

FILE: rtl/core/bqiw_check.sv
module bqiw_check (
  input logic                                             clk,
  input logic                                             rst,
  input logic                                             s_tready,
  input logic                                             m_tvalid,
  input logic                                             m_tready,
  input logic [bqiw_pkg::NPTS*bqiw_pkg::WEIGHT_WIDTH-1:0] m_tdata,
  input logic                                             m_tuser
);

  // held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("held result changed");

  // singular result carries zero weights
  a_sing: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("singular result with nonzero weights");

  // input side only stalls while a result is waiting
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !$past(m_tready))
    else $error("input stalled with no waiting result");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output valid straight after reset");

endmodule

bind bilinear_quad_interp_weights bqiw_check u_check (.*);
